### design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int CODE_BITS = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    // Per-request command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

`default_nettype wire

### design/stable_priority_queue_top.sv
// The result of an accepted request is registered on the output in the next cycle.
// Throughput: one request per cycle while o_stall is low; every cell compares and shifts in the same cycle,
// so the rate is set by the single compare-and-select step of the cell chain.
// A request is taken while a finished result waits, as long as the output is not stalled.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// stored entries are not cleared, the fill count alone marks them as valid.
`default_nettype none

module stable_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_req_type,
    input  wire logic [CODE_BITS-1:0] i_item_code,
    input  wire logic [PRIO_BITS-1:0] i_item_priority,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_status,
    output logic [CODE_BITS-1:0]      o_out_code,
    output logic [PRIO_BITS-1:0]      o_out_priority,
    output logic [CNT_W-1:0]          o_occupancy
);

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    t_cell_cmd            cmd;
    t_entry               new_entry;
    t_entry               cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_take;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_valid;
    logic                 n_valid;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    t_entry               r_out;
    t_entry               n_out;

    // Hold the request side only while a result waits and the consumer stalls
    assign o_stall  = r_valid && i_stall;
    assign accept   = i_valid && !o_stall;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    assign new_entry.code = i_item_code;
    assign new_entry.prio = i_item_priority;

    // Drop inserts into a full queue and removes from an empty one
    assign cmd.ins = accept && (i_req_type == REQ_INSERT) && !is_full;
    assign cmd.rem = accept && (i_req_type == REQ_REMOVE) && !is_empty;

    // Cell chain: cell 0 is the front. On insert the cells at and behind the
    // insertion point shift back by one; on remove every cell takes its right neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_entry;
        logic   left_take;
        t_entry right_entry;

        if (g == 0) begin : g_front
            assign left_entry = new_entry;
            assign left_take  = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[g-1];
            assign left_take  = cell_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign right_entry = cell_entry[g];
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_occupied  (CNT_W'(g) < r_count),
            .i_new       (new_entry),
            .i_left      (left_entry),
            .i_left_take (left_take),
            .i_right     (right_entry),
            .o_entry     (cell_entry[g]),
            .o_take      (cell_take[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_valid  = r_valid && i_stall;
        n_status = r_status;
        n_out    = r_out;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        if (accept) begin
            // Load a fresh result; removed entry is shown only on a successful remove
            n_valid  = 1'b1;
            n_status = ST_OK;
            n_out    = '0;
            if (i_req_type == REQ_INSERT) begin
                if (is_full) begin
                    n_status = ST_FULL;
                end
            end else begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out = cell_entry[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Result payload: no reset needed, qualified by r_valid.
    // Occupancy is taken from the count after the request.
    logic [CNT_W-1:0] r_occ;

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
        if (accept) begin
            r_occ <= n_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_code     = r_out.code;
    assign o_out_priority = r_out.prio;
    assign o_occupancy    = r_occ;

endmodule

`default_nettype wire

### design/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_occupied,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire logic      i_left_take,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_take
);

    t_entry r_entry;
    t_entry n_entry;

    // New item belongs at or before this cell: empty, or stored priority is greater
    assign o_take = !i_occupied || (r_entry.prio > i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && o_take) begin
            n_entry = i_left_take ? i_left : i_new;
        end else if (i_cmd.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### design/spq_checker.sv
`default_nettype none

module spq_assertions
    import spq_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic [1:0]           o_status,
    input wire logic [CODE_BITS-1:0] o_out_code,
    input wire logic [PRIO_BITS-1:0] o_out_priority,
    input wire logic [CNT_W-1:0]     o_occupancy
);

    // No result may come out of reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A full status reports occupancy at the depth
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_occupancy == CNT_W'(DEPTH)))
        else $error("full status with occupancy below depth");

    // An empty status reports an empty queue and no entry
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |->
            (o_occupancy == '0) && (o_out_code == '0) && (o_out_priority == '0))
        else $error("empty status with stored entries or a returned entry");

    // Occupancy never exceeds the depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy beyond depth");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_code)
            && $stable(o_out_priority) && $stable(o_occupancy))
        else $error("stalled result changed");

endmodule

bind stable_priority_queue_top spq_assertions u_spq_assertions (.*);

`default_nettype wire
